// ===== hw/rtl/xcfr_pkg.sv =====
// Shared types and constants for the XOR-checked frame receiver.
// Used by the front parser, the result queue, the output stage and the top level.
package xcfr_pkg;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'hCD;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'hDC;
    localparam int         QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes
    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    // Input operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADSUM  = 2'd1,
        ST_BADHDR  = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        PH_HDR1 = 7'b0000001,
        PH_HDR2 = 7'b0000010,
        PH_ADDR = 7'b0000100,
        PH_CMD  = 7'b0001000,
        PH_LEN  = 7'b0010000,
        PH_PAY  = 7'b0100000,
        PH_CHK  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] frame_address;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        status_t    status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/xcfr_front.sv =====
// Front parser: accepts received words, tracks the frame phase and builds result words.
// Depends on xcfr_pkg.
module xcfr_front
    import xcfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic          accept,
    input  logic          operation,
    input  logic [7:0]    rx_byte,
    output logic          push,
    output result_t       push_word
);

    logic [7:0] header_first_reg, header_first_next;
    logic [7:0] header_second_reg, header_second_next;
    phase_t     phase_reg, phase_next;
    logic       match_reg, match_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] left_dec;

    always_comb
    begin
        header_first_next  = header_first_reg;
        header_second_next = header_second_reg;
        if (cfg_write)
        begin
            if (cfg_index == CFG_HEADER_FIRST)
            begin
                header_first_next = cfg_data;
            end
            else
            begin
                header_second_next = cfg_data;
            end
        end
    end

    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        xor_next   = xor_reg;
        push       = 1'b0;
        push_word.kind          = KIND_END;
        push_word.payload_byte  = 8'd0;
        push_word.frame_address = addr_reg;
        push_word.frame_command = cmd_reg;
        push_word.frame_length  = len_reg;
        push_word.status        = ST_OK;
        push_word.last          = 1'b1;

        if (accept)
        begin
            if (operation == OP_TIMEOUT)
            begin
                // Close any open frame with timeout status
                if (phase_reg != PH_HDR1)
                begin
                    push             = 1'b1;
                    push_word.status = ST_TIMEOUT;
                    phase_next       = PH_HDR1;
                    match_next       = 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HDR1:
                    begin
                        match_next = (rx_byte == header_first_reg);
                        addr_next  = 8'd0;
                        cmd_next   = 8'd0;
                        len_next   = 8'd0;
                        left_next  = 8'd0;
                        xor_next   = 8'd0;
                        phase_next = PH_HDR2;
                    end
                    PH_HDR2:
                    begin
                        match_next = match_reg && (rx_byte == header_second_reg);
                        phase_next = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        addr_next  = rx_byte;
                        xor_next   = rx_byte;
                        phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        cmd_next   = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        len_next = rx_byte;
                        xor_next = xor_reg ^ rx_byte;
                        if (!match_reg)
                        begin
                            push                   = 1'b1;
                            push_word.frame_length = rx_byte;
                            push_word.status       = ST_BADHDR;
                            phase_next             = PH_HDR1;
                            match_next             = 1'b1;
                        end
                        else
                        begin
                            left_next  = rx_byte;
                            phase_next = (rx_byte != 8'd0) ? PH_PAY : PH_CHK;
                        end
                    end
                    PH_PAY:
                    begin
                        xor_next  = xor_reg ^ rx_byte;
                        left_next = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            phase_next = PH_CHK;
                        end
                        push                   = 1'b1;
                        push_word.kind         = KIND_PAYLOAD;
                        push_word.payload_byte = rx_byte;
                        push_word.last         = 1'b0;
                    end
                    PH_CHK:
                    begin
                        push             = 1'b1;
                        push_word.status = (rx_byte == xor_reg) ? ST_OK : ST_BADSUM;
                        phase_next       = PH_HDR1;
                        match_next       = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_HDR1;
                        match_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RESET;
            header_second_reg <= HEADER_SECOND_RESET;
            phase_reg         <= PH_HDR1;
            match_reg         <= 1'b1;
            addr_reg          <= 8'd0;
            cmd_reg           <= 8'd0;
            len_reg           <= 8'd0;
            left_reg          <= 8'd0;
            xor_reg           <= 8'd0;
        end
        else
        begin
            header_first_reg  <= header_first_next;
            header_second_reg <= header_second_next;
            phase_reg         <= phase_next;
            match_reg         <= match_next;
            addr_reg          <= addr_next;
            cmd_reg           <= cmd_next;
            len_reg           <= len_next;
            left_reg          <= left_next;
            xor_reg           <= xor_next;
        end
    end

endmodule

// ===== hw/rtl/xcfr_queue.sv =====
// Short first-in first-out queue of result words between the parser and the output stage.
// Depends on xcfr_pkg.
module xcfr_queue
    import xcfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_t       push_word,
    input  logic          pop,
    output result_t       head_word,
    output queue_status_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/xcfr_back.sv =====
// Output stage: moves result words from the queue into the output register.
// Depends on xcfr_pkg.
module xcfr_back
    import xcfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_stat,
    input  result_t       head_word,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       out_word
);

    logic    valid_reg, valid_next;
    result_t word_reg, word_next;

    // Refill when the register is empty or its word leaves this cycle
    assign pop = !q_stat.empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            word_next  = head_word;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== hw/rtl/xor_checked_frame_receiver_core.sv =====
// Top level of the XOR-checked frame receiver.
// Depends on xcfr_pkg, xcfr_front, xcfr_queue and xcfr_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per received event:
//   operation selects a received byte (rx_byte) or a receive gap timeout.
//   Frames are: header byte one, header byte two, address, command, length,
//   length payload bytes, check byte (XOR of address, command, length and
//   payload). Each payload byte leaves at once as a payload word; the check
//   byte, a wrong header (judged after the fifth byte) or a mid-frame
//   timeout give one end word with status and last set.
//   Output channel (out_valid/out_ready) carries the result words in order.
//   A word that makes a result is written into the queue at the edge that
//   accepts it; the output stage then pops it into the output register.
//   Throughput: one input word per cycle while the queue is not full; the
//   parser updates its state once per accepted word, so the block sustains
//   one word per clock until in_ready drops.
//   Stall: when the receiver holds out_ready low, results collect in the
//   QUEUE_DEPTH-entry queue; in_ready drops only once the queue is full.
//   Reset (rst_n, asynchronous, active low) returns the parser to waiting
//   for header byte one, empties the queue and reloads the header registers
//   (0xCD, 0xDC). Write header registers over cfg_write/cfg_index/cfg_data
//   only while the block is idle.
module xor_checked_frame_receiver_core
    import xcfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] payload_byte,
    output logic [7:0] frame_address,
    output logic [7:0] frame_command,
    output logic [7:0] frame_length,
    output logic [1:0] status,
    output logic       last
);

    logic          accept;
    logic          q_push;
    logic          q_pop;
    result_t       q_in_word;
    result_t       q_head_word;
    result_t       out_word;
    queue_status_t q_stat;

    // Accept whenever the queue can take a result
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    xcfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .operation (operation),
        .rx_byte   (rx_byte),
        .push      (q_push),
        .push_word (q_in_word)
    );

    xcfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in_word),
        .pop       (q_pop),
        .head_word (q_head_word),
        .stat      (q_stat)
    );

    xcfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_word (q_head_word),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // Drive the payload ports from the output register
    assign kind          = out_word.kind;
    assign payload_byte  = out_word.payload_byte;
    assign frame_address = out_word.frame_address;
    assign frame_command = out_word.frame_command;
    assign frame_length  = out_word.frame_length;
    assign status        = out_word.status;
    assign last          = out_word.last;

    // An end word always closes the frame, and only end words do
    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == last))
        else $error("end word and last flag disagree");

    // Payload words always carry ok status
    a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_PAYLOAD)) |-> (status == ST_OK))
        else $error("payload word with non-ok status");

    // Never pop an empty queue; the output register then holds a word
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_stat.empty ##1 out_valid))
        else $error("queue pop without a word delivered");

    // A result pushed into an empty queue with an idle output passes through the queue into the output register
    a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_stat.empty && !out_valid) |=> ##1 out_valid)
        else $error("result did not reach the output in two cycles");

endmodule

// ===== tb/xor_checked_frame_receiver_core_tb.sv =====
// Testbench for xor_checked_frame_receiver_core: sends received-byte and timeout words
// and checks every payload word and end report against a frame parser kept in the bench.
// Depends on xcfr_pkg and the RTL of xor_checked_frame_receiver_core.
module xor_checked_frame_receiver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xcfr_pkg::*;

    // Generous ceiling: the slowest phases idle or stall most of the time on either side.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 300;

    // Parser steps of the bench's own frame model
    typedef enum logic [2:0] {
        FR_HDR1 = 3'd0,
        FR_HDR2 = 3'd1,
        FR_ADDR = 3'd2,
        FR_CMD  = 3'd3,
        FR_LEN  = 3'd4,
        FR_PAY  = 3'd5,
        FR_CHK  = 3'd6
    } frame_step_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = CFG_HEADER_FIRST;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic       operation = OP_BYTE;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_address;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic [1:0] status;
    logic       last;

    // Bench copy of the header registers and the parser state
    logic [7:0]  hdr_first_q  = HEADER_FIRST_RESET;
    logic [7:0]  hdr_second_q = HEADER_SECOND_RESET;
    frame_step_t step         = FR_HDR1;
    logic        hdr_ok       = 1'b1;
    logic [7:0]  held_addr    = 8'h00;
    logic [7:0]  held_cmd     = 8'h00;
    logic [7:0]  held_len     = 8'h00;
    logic [7:0]  left_cnt     = 8'h00;
    logic [7:0]  sum_xor      = 8'h00;

    // Results the parser has produced and the output has not yet shown, oldest first
    result_t frame_results[$];

    int unsigned mismatches  = 0;
    int unsigned sent_words  = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned hold_left   = 0;
    bit          hold_armed  = 1'b0;

    xor_checked_frame_receiver_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .payload_byte  (payload_byte),
        .frame_address (frame_address),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .status        (status),
        .last          (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Advance the bench parser by one accepted word and queue the result it causes, if any.
    // Head fields are cleared on header byte one, so an early timeout reports zeros there.
    function automatic void parse_rx_word(input logic op, input logic [7:0] b);
        result_t r;
        logic    emit;
        logic    is_end;
        status_t st;
        logic [7:0] pay;
        emit   = 1'b0;
        is_end = 1'b0;
        st     = ST_OK;
        pay    = 8'h00;
        if (step > FR_CHK)
        begin
            step   = FR_HDR1;
            hdr_ok = 1'b1;
        end
        if (op == OP_TIMEOUT)
        begin
            // A gap while idle says nothing; in a frame it wins over a pending bad header
            if (step != FR_HDR1)
            begin
                emit   = 1'b1;
                is_end = 1'b1;
                st     = ST_TIMEOUT;
                step   = FR_HDR1;
                hdr_ok = 1'b1;
            end
        end
        else
        begin
            case (step)
                FR_HDR1:
                begin
                    hdr_ok    = (b == hdr_first_q);
                    held_addr = 8'h00;
                    held_cmd  = 8'h00;
                    held_len  = 8'h00;
                    left_cnt  = 8'h00;
                    sum_xor   = 8'h00;
                    step      = FR_HDR2;
                end
                FR_HDR2:
                begin
                    hdr_ok = hdr_ok && (b == hdr_second_q);
                    step   = FR_ADDR;
                end
                FR_ADDR:
                begin
                    held_addr = b;
                    sum_xor   = b;
                    step      = FR_CMD;
                end
                FR_CMD:
                begin
                    held_cmd = b;
                    sum_xor  = sum_xor ^ b;
                    step     = FR_LEN;
                end
                FR_LEN:
                begin
                    held_len = b;
                    sum_xor  = sum_xor ^ b;
                    if (!hdr_ok)
                    begin
                        emit   = 1'b1;
                        is_end = 1'b1;
                        st     = ST_BADHDR;
                        step   = FR_HDR1;
                        hdr_ok = 1'b1;
                    end
                    else
                    begin
                        left_cnt = b;
                        // Zero length goes straight to the check byte
                        step = (b != 8'h00) ? FR_PAY : FR_CHK;
                    end
                end
                FR_PAY:
                begin
                    sum_xor  = sum_xor ^ b;
                    left_cnt = left_cnt - 8'd1;
                    if (left_cnt == 8'h00)
                        step = FR_CHK;
                    emit = 1'b1;
                    pay  = b;
                end
                default:
                begin
                    emit   = 1'b1;
                    is_end = 1'b1;
                    st     = (b == sum_xor) ? ST_OK : ST_BADSUM;
                    step   = FR_HDR1;
                    hdr_ok = 1'b1;
                end
            endcase
        end
        if (emit)
        begin
            r.kind          = is_end ? KIND_END : KIND_PAYLOAD;
            r.payload_byte  = pay;
            r.frame_address = held_addr;
            r.frame_command = held_cmd;
            r.frame_length  = held_len;
            r.status        = st;
            r.last          = is_end;
            frame_results.push_back(r);
        end
    endfunction

    // Offer one word, idling first at the current sender rate. Valid stays high after the
    // handshake; the next call or drain_block lowers or reuses it in the same step.
    task automatic send_word(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        parse_rx_word(op, b);
        sent_words++;
    endtask

    // Drop valid, wait for every queued result, then let the pipeline settle.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both header registers; only call with the block idle.
    task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
        cfg_write <= 1'b1;
        cfg_index <= CFG_HEADER_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= CFG_HEADER_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        cfg_write <= 1'b0;
        hdr_first_q  = first;
        hdr_second_q = second;
    endtask

    // One frame with random content: mostly well formed, some with a bad check byte,
    // a bad header, a timeout part way through, or loose noise.
    task automatic send_random_frame();
        logic [7:0]  fb[$];
        logic [7:0]  sum;
        int unsigned mode;
        int unsigned len;
        int unsigned cut;
        int unsigned k;
        mode = $urandom_range(99);
        if (mode >= 95)
        begin
            // Loose words, then a timeout so the next frame starts clean
            k = $urandom_range(3, 1);
            repeat (k) send_word(1'($urandom_range(1)), 8'($urandom_range(255)));
            send_word(OP_TIMEOUT, 8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(19) == 0)
            len = $urandom_range(24, 7);
        else
            len = $urandom_range(6, 0);
        fb.push_back(hdr_first_q);
        fb.push_back(hdr_second_q);
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'(len));
        sum = fb[2] ^ fb[3] ^ fb[4];
        for (k = 0; k < len; k++)
        begin
            fb.push_back(8'($urandom_range(255)));
            sum = sum ^ fb[fb.size() - 1];
        end
        if (mode >= 70 && mode < 80)
            fb.push_back(sum ^ 8'($urandom_range(255, 1)));
        else
            fb.push_back(sum);
        cut = fb.size();
        if (mode >= 80 && mode < 88)
        begin
            // Spoil one or both header bytes; only the head goes out, the report ends it
            case ($urandom_range(2))
                0:       fb[0] = fb[0] ^ 8'($urandom_range(255, 1));
                1:       fb[1] = fb[1] ^ 8'($urandom_range(255, 1));
                default:
                begin
                    fb[0] = fb[0] ^ 8'($urandom_range(255, 1));
                    fb[1] = fb[1] ^ 8'($urandom_range(255, 1));
                end
            endcase
            cut = 5;
        end
        else if (mode >= 88)
            cut = $urandom_range(fb.size() - 1, 1);
        for (k = 0; k < cut; k++)
            send_word(OP_BYTE, fb[k]);
        if (cut < fb.size() && mode >= 88)
            send_word(OP_TIMEOUT, 8'($urandom_range(255)));
    endtask

    // Reset headers, no idling: each status, the byte extremes and the timeout corners.
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        // Timeout while idle: no report
        send_word(OP_TIMEOUT, 8'hFF);
        // Zero-length good frame, address and command at the extremes
        send_word(OP_BYTE, HEADER_FIRST_RESET);
        send_word(OP_BYTE, HEADER_SECOND_RESET);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        // Two payload bytes at the extremes, then a wrong check byte
        send_word(OP_BYTE, HEADER_FIRST_RESET);
        send_word(OP_BYTE, HEADER_SECOND_RESET);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h02);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFD);
        // Wrong first header byte, judged on the length byte
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, HEADER_SECOND_RESET);
        send_word(OP_BYTE, 8'h12);
        send_word(OP_BYTE, 8'h34);
        send_word(OP_BYTE, 8'h01);
        // Both header bytes wrong, then a gap before the header is judged
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_TIMEOUT, 8'h5A);
        drain_block();
    endtask

    // Header registers at both extremes and one odd pair, a few frames each.
    task automatic test_header_extremes();
        set_headers(8'h00, 8'h00);
        repeat (4) send_random_frame();
        drain_block();
        set_headers(8'hFF, 8'hFF);
        repeat (4) send_random_frame();
        drain_block();
        set_headers(8'h5A, 8'hA5);
        repeat (4) send_random_frame();
        drain_block();
    endtask

    // Random frames at one pair of idle rates, with fresh headers unless told to keep them.
    task automatic test_random(input int unsigned send_idle, input int unsigned recv_stall,
                               input bit new_headers, input int unsigned count);
        int unsigned start;
        if (new_headers)
            set_headers(8'($urandom_range(255)), 8'($urandom_range(255)));
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        start     = sent_words;
        while (sent_words - start < count)
            send_random_frame();
        drain_block();
    endtask

    // Hold the receiver off while a maximal frame streams in, so the queue fills up
    // and the input stalls.
    task automatic test_backpressure();
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned k;
        set_headers(HEADER_FIRST_RESET, HEADER_SECOND_RESET);
        idle_pct   = 0;
        stall_pct  = 0;
        hold_armed = 1'b1;
        send_word(OP_BYTE, hdr_first_q);
        send_word(OP_BYTE, hdr_second_q);
        send_word(OP_BYTE, 8'hA3);
        send_word(OP_BYTE, 8'h3C);
        send_word(OP_BYTE, 8'hFF);
        sum = 8'hA3 ^ 8'h3C ^ 8'hFF;
        for (k = 0; k < 255; k++)
        begin
            b   = 8'($urandom_range(255));
            sum = sum ^ b;
            send_word(OP_BYTE, b);
        end
        send_word(OP_BYTE, sum);
        drain_block();
    endtask

    // Receiver: stall at the current rate, or hold off entirely while a long hold runs.
    always @(posedge clk)
    begin
        if (hold_armed)
        begin
            hold_armed = 1'b0;
            hold_left  = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left  = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every output word with the oldest predicted result.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results.size() == 0)
            begin
                $display("%0t ns: unexpected word kind %b status %0d", $time, kind, status);
                mismatches++;
            end
            else
            begin
                want = frame_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(kind));
                check_field("payload_byte", want.payload_byte, payload_byte);
                check_field("frame_address", want.frame_address, frame_address);
                check_field("frame_command", want.frame_command, frame_command);
                check_field("frame_length", want.frame_length, frame_length);
                check_field("status", 8'(want.status), 8'(status));
                check_field("last", 8'(want.last), 8'(last));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("xor_checked_frame_receiver_core_tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);
        test_directed();
        test_header_extremes();
        test_random(0, 0, 1'b0, 50);
        test_random(86, 0, 1'b1, 50);
        test_random(0, 86, 1'b1, 50);
        test_random(30, 30, 1'b1, 50);
        test_backpressure();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && frame_results.size() == 0)
            $display("xor_checked_frame_receiver_core_tb OK");
        else
            $display("xor_checked_frame_receiver_core_tb NOT OK");
        $finish;
    end

endmodule
